@@ sv/sha1_message_digest_assert.svh @@
// ----------------------------------------------------------------------------
// sha1 message digest assertion macros
// clocked property wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// property sampled on clk, off during reset
`define SHA1MD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// property that must never be true
`define SHA1MD_NEVER(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(prop)) \
		else $error(msg);

`endif

@@ sv/sha1md_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1md_pkg
// item types, sequencer codes and round functions of the sha-1 engine
// ----------------------------------------------------------------------------
package sha1md_pkg;

	localparam int unsigned ROUNDS       = 80;
	localparam int unsigned BLOCK_WORDS  = 16;
	localparam int unsigned DIGEST_WORDS = 5;

	localparam logic [31:0] PAD_MARK = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  valid_bytes;
		logic        final_word;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        digest_last;
	} digest_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_MARK,
		PH_ZERO,
		PH_LEN_LO,
		PH_DONE
	} pad_phase_t;

	// control from the sequencer to the datapath
	typedef struct packed {
		logic        push;
		logic [31:0] push_data;
		logic        load;
		logic        round;
		logic [6:0]  round_idx;
		logic        fold;
		logic        reinit;
		logic [2:0]  digest_sel;
	} dp_ctrl_t;

	function automatic logic [31:0] h_init(input logic [2:0] idx);
		logic [31:0] h;
		case (idx)
			3'd0:    h = 32'h6745_2301;
			3'd1:    h = 32'hEFCD_AB89;
			3'd2:    h = 32'h98BA_DCFE;
			3'd3:    h = 32'h1032_5476;
			default: h = 32'hC3D2_E1F0;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] t);
		logic [31:0] k;
		if (t < 7'd20)
			k = 32'h5A82_7999;
		else if (t < 7'd40)
			k = 32'h6ED9_EBA1;
		else if (t < 7'd60)
			k = 32'h8F1B_BCDC;
		else
			k = 32'hCA62_C1D6;
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (t < 7'd20)
			f = (b & c) | (~b & d);
		else if (t >= 7'd40 && t < 7'd60)
			f = (b & c) | (b & d) | (c & d);
		else
			f = b ^ c ^ d;
		return f;
	endfunction

endpackage

@@ sv/sha1md_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha1md_ctrl
// sequencer: word intake, padding, round count, digest readout
// ----------------------------------------------------------------------------
module sha1md_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   msg_valid,
	input  sha1md_pkg::msg_item_t  msg,
	output logic                   msg_ready,
	output logic                   digest_valid,
	input  logic                   digest_ready,
	output logic                   digest_last,
	output sha1md_pkg::dp_ctrl_t   dp
);
	import sha1md_pkg::*;

	localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
	localparam logic [3:0] LEN_SLOT   = 4'(BLOCK_WORDS - 2);
	localparam logic [3:0] LAST_SLOT  = 4'(BLOCK_WORDS - 1);
	localparam logic [2:0] LAST_SEL   = 3'(DIGEST_WORDS - 1);

	state_t     state_q, state_d;
	pad_phase_t phase_q;
	logic       pad_active_q;
	logic [3:0] fill_q;
	logic [6:0] round_q;
	logic [2:0] sel_q;
	logic [63:0] bitlen_q;

	logic [2:0]  nb;
	logic [31:0] keep;
	logic [31:0] mark;
	logic [31:0] first_word;
	logic        msg_acc;
	logic        digest_acc;
	logic        push;
	logic [31:0] push_data;
	logic        block_full;

	assign msg_acc    = msg_valid && msg_ready;
	assign digest_acc = digest_valid && digest_ready;

	// byte count: non-final words and counts above four are full words
	always_comb begin
		nb = (!msg.final_word || msg.valid_bytes > 3'd4) ? 3'd4 : msg.valid_bytes;
		case (nb)
			3'd0:    begin keep = 32'h0000_0000; mark = 32'h8000_0000; end
			3'd1:    begin keep = 32'hFF00_0000; mark = 32'h0080_0000; end
			3'd2:    begin keep = 32'hFFFF_0000; mark = 32'h0000_8000; end
			3'd3:    begin keep = 32'hFFFF_FF00; mark = 32'h0000_0080; end
			default: begin keep = 32'hFFFF_FFFF; mark = 32'h0000_0000; end
		endcase
		first_word = (msg.message_word & keep) | mark;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (msg_acc) begin
					if (block_full)
						state_d = ST_ROUND;
					else if (msg.final_word)
						state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (phase_q == PH_DONE)
					state_d = ST_OUT;
				else if (block_full)
					state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (round_q == LAST_ROUND)
					state_d = ST_FOLD;
			end
			ST_FOLD: begin
				state_d = pad_active_q ? ST_PAD : ST_IDLE;
			end
			ST_OUT: begin
				if (digest_acc && sel_q == LAST_SEL)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		msg_ready    = 1'b0;
		digest_valid = 1'b0;
		push         = 1'b0;
		push_data    = '0;
		unique case (state_q)
			ST_IDLE: begin
				msg_ready = 1'b1;
				push      = msg_valid;
				push_data = first_word;
			end
			ST_PAD: begin
				unique case (phase_q)
					PH_MARK: begin
						push      = 1'b1;
						push_data = PAD_MARK;
					end
					PH_ZERO: begin
						push      = 1'b1;
						push_data = (fill_q == LEN_SLOT) ? bitlen_q[63:32] : '0;
					end
					PH_LEN_LO: begin
						push      = 1'b1;
						push_data = bitlen_q[31:0];
					end
					default: push = 1'b0;
				endcase
			end
			ST_OUT:  digest_valid = 1'b1;
			default: push = 1'b0;
		endcase
	end

	assign block_full  = push && fill_q == LAST_SLOT;
	assign digest_last = sel_q == LAST_SEL;

	always_comb begin
		dp            = '0;
		dp.push       = push;
		dp.push_data  = push_data;
		dp.load       = block_full;
		dp.round      = state_q == ST_ROUND;
		dp.round_idx  = round_q;
		dp.fold       = state_q == ST_FOLD;
		dp.reinit     = digest_acc && digest_last;
		dp.digest_sel = sel_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_DONE;
			pad_active_q <= 1'b0;
			fill_q       <= '0;
			round_q      <= '0;
			sel_q        <= '0;
			bitlen_q     <= '0;
		end else begin
			state_q <= state_d;
			if (push)
				fill_q <= fill_q + 4'd1;
			if (msg_acc) begin
				bitlen_q     <= bitlen_q + {58'd0, nb, 3'd0};
				pad_active_q <= msg.final_word;
				phase_q      <= (nb == 3'd4) ? PH_MARK : PH_ZERO;
			end
			if (state_q == ST_PAD) begin
				unique case (phase_q)
					PH_MARK:   phase_q <= PH_ZERO;
					PH_ZERO:   if (fill_q == LEN_SLOT) phase_q <= PH_LEN_LO;
					PH_LEN_LO: phase_q <= PH_DONE;
					default:   phase_q <= phase_q;
				endcase
			end
			if (state_q == ST_ROUND)
				round_q <= (round_q == LAST_ROUND) ? '0 : round_q + 7'd1;
			if (digest_acc) begin
				sel_q <= digest_last ? '0 : sel_q + 3'd1;
				if (digest_last) begin
					pad_active_q <= 1'b0;
					bitlen_q     <= '0;
				end
			end
		end
	end

endmodule

@@ sv/sha1md_sched.sv @@
// ----------------------------------------------------------------------------
// sha1md_sched
// 16-word message schedule window, fixed taps, one word per cycle on push or round
// ----------------------------------------------------------------------------
module sha1md_sched (
	input  logic                 clk,
	input  sha1md_pkg::dp_ctrl_t dp,
	output logic [31:0]          w_t
);
	import sha1md_pkg::*;

	logic [31:0] win_q [BLOCK_WORDS];
	logic [31:0] mix;

	// window holds w[t-16] at index 0 through w[t-1] at the top
	assign mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign w_t = (dp.round_idx < 7'(BLOCK_WORDS)) ? win_q[0] : {mix[30:0], mix[31]};

	always_ff @(posedge clk) begin
		if (dp.push || dp.round) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++)
				win_q[i] <= win_q[i + 1];
			win_q[BLOCK_WORDS - 1] <= dp.push ? dp.push_data : w_t;
		end
	end

endmodule

@@ sv/sha1md_core.sv @@
// ----------------------------------------------------------------------------
// sha1md_core
// shared round unit, working variables and chaining value
// ----------------------------------------------------------------------------
module sha1md_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1md_pkg::dp_ctrl_t dp,
	input  logic [31:0]          w_t,
	output logic [31:0]          digest_word
);
	import sha1md_pkg::*;

	logic [31:0] chain_q [DIGEST_WORDS];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] t_sum;

	assign t_sum = {a_q[26:0], a_q[31:27]} + round_f(dp.round_idx, b_q, c_q, d_q)
		+ e_q + w_t + round_k(dp.round_idx);

	always_comb begin
		case (dp.digest_sel)
			3'd0:    digest_word = chain_q[0];
			3'd1:    digest_word = chain_q[1];
			3'd2:    digest_word = chain_q[2];
			3'd3:    digest_word = chain_q[3];
			default: digest_word = chain_q[4];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			d_q <= '0;
			e_q <= '0;
		end else if (dp.load) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (dp.round) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGEST_WORDS; i++)
				chain_q[i] <= h_init(3'(i));
		end else if (dp.reinit) begin
			for (int i = 0; i < DIGEST_WORDS; i++)
				chain_q[i] <= h_init(3'(i));
		end else if (dp.fold) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q;
		end
	end

endmodule

@@ sv/sha1_message_digest.sv @@
// ----------------------------------------------------------------------------
// sha1_message_digest
// sha-1 hash engine with message padding and digest readout
// ----------------------------------------------------------------------------
// A message enters as big-endian 32-bit items (first byte in bits 31..24),
// the last one marked by final_word with its used byte count in valid_bytes.
// The sixteenth word of a block starts the compression: one shared round
// unit runs the 80 rounds one per cycle, then a fold step adds the result
// into the chaining value. On the final item the engine inserts the 0x80
// byte, zero words and the 64-bit bit length one word per cycle, with one
// or two compressions, then offers the five digest items H0..H4
// (digest_last on H4) and starts over for the next message. msg_ready is
// low while padding, compressing or reading out.
// ----------------------------------------------------------------------------
module sha1_message_digest (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     msg_valid,
	output logic                     msg_ready,
	input  sha1md_pkg::msg_item_t    msg,
	output logic                     digest_valid,
	input  logic                     digest_ready,
	output sha1md_pkg::digest_item_t digest
);
	import sha1md_pkg::*;

	// sequencer to datapath control
	dp_ctrl_t    dp;
	// current schedule word for the active round
	logic [31:0] w_t;
	logic [31:0] digest_word;
	logic        digest_last;

	// sequencer: intake, padding, round counting, readout
	sha1md_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg          (msg),
		.msg_ready    (msg_ready),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest_last  (digest_last),
		.dp           (dp)
	);

	// message schedule window
	sha1md_sched u_sched (
		.clk (clk),
		.dp  (dp),
		.w_t (w_t)
	);

	// round unit and chaining value
	sha1md_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp          (dp),
		.w_t         (w_t),
		.digest_word (digest_word)
	);

	// digest items are read straight from the chaining registers
	assign digest.digest_word = digest_word;
	assign digest.digest_last = digest_last;

endmodule

@@ sv/sha1md_check.sv @@
// ----------------------------------------------------------------------------
// sha1md_check
// port-level checks of the sha-1 engine, bound to the top level
// ----------------------------------------------------------------------------
`include "sha1_message_digest_assert.svh"

module sha1md_check (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     msg_valid,
	input logic                     msg_ready,
	input sha1md_pkg::msg_item_t    msg,
	input logic                     digest_valid,
	input logic                     digest_ready,
	input sha1md_pkg::digest_item_t digest
);
	import sha1md_pkg::*;

	// no intake while a digest is offered
	`SHA1MD_NEVER(a_no_overlap, msg_ready && digest_valid, "intake open during readout")

	// a final item always drops msg_ready for padding or compression
	`SHA1MD_ASSERT(a_final_busy, msg_valid && msg_ready && msg.final_word |=> !msg_ready,
		"ready right after final item")

	// readout ends with the last digest item
	`SHA1MD_ASSERT(a_last_ends, digest_valid && digest_ready && digest.digest_last |=> !digest_valid,
		"digest offered after last item")

	// a stalled digest item holds
	`SHA1MD_ASSERT(a_out_hold, digest_valid && !digest_ready |=> digest_valid && $stable(digest),
		"stalled digest item changed")

endmodule

bind sha1_message_digest sha1md_check u_check (.*);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// sha-1 message digest engine testbench
// streams messages word by word with random gaps on both sides, predicts the
// five digest words of each message in a local sha-1 model and compares
// every digest item as it leaves the engine
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sha1md_pkg::*;

	// run limits in clock cycles
	localparam int unsigned CYCLE_LIMIT   = 200_000;
	localparam int unsigned SETTLE_CYCLES = 250;    // two compressions plus readout
	localparam int unsigned RANDOM_WORDS  = 170;
	localparam int unsigned HOLD_CYCLES   = 600;

	// sha-1 starting chain, kept locally for the predictor
	localparam logic [31:0] IV_A = 32'h6745_2301;
	localparam logic [31:0] IV_B = 32'hEFCD_AB89;
	localparam logic [31:0] IV_C = 32'h98BA_DCFE;
	localparam logic [31:0] IV_D = 32'h1032_5476;
	localparam logic [31:0] IV_E = 32'hC3D2_E1F0;

	logic         clk;
	logic         arst_n       = 1'b0;
	logic         msg_valid    = 1'b0;
	logic         msg_ready;
	msg_item_t    msg          = '0;
	logic         digest_valid;
	logic         digest_ready = 1'b0;
	digest_item_t digest;

	// predictor state: chain value, 16-word schedule, length in bits, fill
	logic [31:0]  chain_h [5];
	logic [31:0]  sched_w [16];
	logic [63:0]  msg_bits;
	int unsigned  blk_fill;

	// digest items still owed by the engine, oldest first
	digest_item_t expected_digest [$];
	digest_item_t digest_head;

	int unsigned  error_count = 0;
	int unsigned  cycle_count = 0;

	// idle budgets: per-item gap limits and the receiver's countdowns
	int unsigned  send_max  = 8;
	int unsigned  take_max  = 8;
	int unsigned  take_gap  = 0;
	int unsigned  hold_left = 0;

	sha1_message_digest u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_ready    (msg_ready),
		.msg          (msg),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest       (digest)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// sha-1 predictor
	// ------------------------------------------------------------------
	function automatic logic [31:0] rol(input logic [31:0] x, input int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic void restart_chain();
		chain_h[0] = IV_A;
		chain_h[1] = IV_B;
		chain_h[2] = IV_C;
		chain_h[3] = IV_D;
		chain_h[4] = IV_E;
		msg_bits = '0;
		blk_fill = 0;
	endfunction

	// 80 rounds over the schedule, folded into the chain value
	function automatic void compress_schedule();
		logic [31:0] a, b, c, d, e, f, k, w, t;
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < 80; r++) begin
			if (r >= 16) begin
				w = sched_w[(r - 3) & 15] ^ sched_w[(r - 8) & 15]
					^ sched_w[(r - 14) & 15] ^ sched_w[r & 15];
				sched_w[r & 15] = rol(w, 1);
			end
			w = sched_w[r & 15];
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A82_7999;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9_EBA1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1B_BCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62_C1D6;
			end
			t = rol(a, 5) + f + e + w + k;
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endfunction

	function automatic void load_word(input logic [31:0] w);
		sched_w[blk_fill] = w;
		blk_fill++;
		if (blk_fill == 16) begin
			compress_schedule();
			blk_fill = 0;
		end
	endfunction

	// take one accepted item; a final item pads, closes the message and
	// queues the five digest words
	function automatic void absorb_item(input msg_item_t item);
		int unsigned  n_bytes;
		logic [31:0]  keep;
		digest_item_t d;
		n_bytes = 32'(item.valid_bytes);
		if (n_bytes > 4 || !item.final_word)
			n_bytes = 4;
		msg_bits = msg_bits + 64'(n_bytes * 8);
		if (!item.final_word) begin
			load_word(item.message_word);
			return;
		end
		if (n_bytes == 4) begin
			load_word(item.message_word);
			load_word(PAD_MARK);
		end else begin
			// bytes past the message are replaced by the 0x80 marker and zeros
			keep = (n_bytes == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * n_bytes));
			load_word((item.message_word & keep) | (32'h80 << (24 - 8 * n_bytes)));
		end
		while (blk_fill != 14)
			load_word(32'h0);
		load_word(msg_bits[63:32]);
		load_word(msg_bits[31:0]);
		for (int k = 0; k < DIGEST_WORDS; k++) begin
			d.digest_word = chain_h[k];
			d.digest_last = (k == DIGEST_WORDS - 1);
			expected_digest.push_back(d);
		end
		restart_chain();
	endfunction

	// ------------------------------------------------------------------
	// digest side: ready with random gaps, plus a long hold when asked
	// ------------------------------------------------------------------
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				digest_ready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				digest_ready <= 1'b0;
			end else begin
				digest_ready <= 1'b1;
			end
		end
	end

	// compare each accepted digest item with the oldest one owed
	always @(posedge clk) begin
		if (arst_n && digest_valid && digest_ready) begin
			if (expected_digest.size() == 0) begin
				$error("digest item with none owed: digest_word %h digest_last %b",
					digest.digest_word, digest.digest_last);
				error_count++;
			end else begin
				digest_head = expected_digest.pop_front();
				if (digest.digest_word !== digest_head.digest_word) begin
					$error("digest_word expected %h actual %h",
						digest_head.digest_word, digest.digest_word);
					error_count++;
				end
				if (digest.digest_last !== digest_head.digest_last) begin
					$error("digest_last expected %b actual %b",
						digest_head.digest_last, digest.digest_last);
					error_count++;
				end
			end
			take_gap = $urandom_range(0, take_max);
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// message side
	// ------------------------------------------------------------------

	// offer one item after a random gap and hold it until taken; valid is
	// left high so a back-to-back item needs no drop in between
	task automatic send_item(input msg_item_t item);
		int unsigned gap;
		gap = $urandom_range(0, send_max);
		@(negedge clk);
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg       <= item;
		msg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!msg_ready);
		absorb_item(item);
	endtask

	// drop valid, then wait for every owed digest item
	task automatic drain_digests();
		@(negedge clk);
		msg_valid <= 1'b0;
		while (expected_digest.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic fin);
		msg_item_t item;
		item.message_word = w;
		item.valid_bytes  = nb;
		item.final_word   = fin;
		send_item(item);
	endtask

	// message of random words; mostly full non-final words, now and then a
	// short count that must still count as four bytes
	task automatic send_message(input int unsigned n_words);
		logic [2:0] nb;
		for (int i = 0; i < n_words; i++) begin
			if (i == n_words - 1)
				nb = 3'($urandom_range(0, 7));
			else if ($urandom_range(0, 7) == 0)
				nb = 3'($urandom_range(0, 7));
			else
				nb = 3'd4;
			send_word($urandom(), nb, i == n_words - 1);
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// empty message: padding starts at the first byte, word bits ignored
	task automatic test_empty_message();
		send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
		drain_digests();
	endtask

	// short final words: "abc" with junk in the unused byte, then an
	// oversized byte count that is taken as four
	task automatic test_short_final();
		send_word(32'h6162_63A5, 3'd3, 1'b1);
		send_word(32'h0000_0000, 3'd7, 1'b1);
		drain_digests();
	endtask

	// 56-byte message: the length no longer fits, so an extra block follows;
	// the non-final words carry odd byte counts and the word extremes
	task automatic test_length_56();
		logic [2:0] nb_list [7];
		logic [31:0] w_list [7];
		nb_list = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7};
		w_list  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0123_4567, 32'h89AB_CDEF,
			32'hFFFF_FFFF, 32'h0000_0000, 32'hA5A5_A5A5};
		for (int i = 0; i < 7; i++)
			send_word(w_list[i], nb_list[i], 1'b0);
		for (int i = 7; i < 13; i++)
			send_word($urandom(), 3'd4, 1'b0);
		send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
		drain_digests();
	endtask

	// random messages; lengths cluster around one block, some span two or
	// three, and about one message in four runs with no idling on either side
	task automatic test_random_messages();
		int unsigned sent;
		int unsigned n_words;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 5) == 0)
				n_words = $urandom_range(12, 40);
			else
				n_words = $urandom_range(1, 18);
			if ($urandom_range(0, 3) == 0) begin
				send_max = 0;
				take_max = 0;
			end else begin
				send_max = 8;
				take_max = 8;
			end
			send_message(n_words);
			sent += n_words;
		end
		send_max = 8;
		take_max = 8;
		drain_digests();
	endtask

	// receiver stalls for a long stretch while messages keep coming, so the
	// readout backs up and the engine must hold off its input
	task automatic test_backpressure();
		send_max = 0;
		take_max = 0;
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		send_message(3);
		send_message(5);
		send_message(14);
		send_message(2);
		drain_digests();
		send_max = 8;
		take_max = 8;
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		restart_chain();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_message();
		test_short_final();
		test_length_56();
		test_random_messages();
		test_backpressure();

		// let the engine go quiet, catching any stray digest item
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
